// ----- design/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    // depth of the block queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned BLOCK_BITS = 512;

    // request kinds
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // padding constants and buffer positions
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    // initial chaining words, word 0 in the top bits
    localparam logic [255:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] message_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
    } t_out_item;

    // one padded or full block handed from front to back
    typedef struct packed {
        logic                  final_block;
        logic [BLOCK_BITS-1:0] data;
    } t_job;

    typedef enum logic [1:0] {F_IDLE, F_MARK, F_ZERO, F_LEN} t_front_state;
    typedef enum logic [1:0] {B_IDLE, B_ROUND, B_ADD, B_EMIT} t_back_state;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // round constants
    function automatic logic [31:0] round_const(input logic [5:0] t);
        case (t)
            6'd0:  round_const = 32'h428a2f98;  6'd1:  round_const = 32'h71374491;
            6'd2:  round_const = 32'hb5c0fbcf;  6'd3:  round_const = 32'he9b5dba5;
            6'd4:  round_const = 32'h3956c25b;  6'd5:  round_const = 32'h59f111f1;
            6'd6:  round_const = 32'h923f82a4;  6'd7:  round_const = 32'hab1c5ed5;
            6'd8:  round_const = 32'hd807aa98;  6'd9:  round_const = 32'h12835b01;
            6'd10: round_const = 32'h243185be;  6'd11: round_const = 32'h550c7dc3;
            6'd12: round_const = 32'h72be5d74;  6'd13: round_const = 32'h80deb1fe;
            6'd14: round_const = 32'h9bdc06a7;  6'd15: round_const = 32'hc19bf174;
            6'd16: round_const = 32'he49b69c1;  6'd17: round_const = 32'hefbe4786;
            6'd18: round_const = 32'h0fc19dc6;  6'd19: round_const = 32'h240ca1cc;
            6'd20: round_const = 32'h2de92c6f;  6'd21: round_const = 32'h4a7484aa;
            6'd22: round_const = 32'h5cb0a9dc;  6'd23: round_const = 32'h76f988da;
            6'd24: round_const = 32'h983e5152;  6'd25: round_const = 32'ha831c66d;
            6'd26: round_const = 32'hb00327c8;  6'd27: round_const = 32'hbf597fc7;
            6'd28: round_const = 32'hc6e00bf3;  6'd29: round_const = 32'hd5a79147;
            6'd30: round_const = 32'h06ca6351;  6'd31: round_const = 32'h14292967;
            6'd32: round_const = 32'h27b70a85;  6'd33: round_const = 32'h2e1b2138;
            6'd34: round_const = 32'h4d2c6dfc;  6'd35: round_const = 32'h53380d13;
            6'd36: round_const = 32'h650a7354;  6'd37: round_const = 32'h766a0abb;
            6'd38: round_const = 32'h81c2c92e;  6'd39: round_const = 32'h92722c85;
            6'd40: round_const = 32'ha2bfe8a1;  6'd41: round_const = 32'ha81a664b;
            6'd42: round_const = 32'hc24b8b70;  6'd43: round_const = 32'hc76c51a3;
            6'd44: round_const = 32'hd192e819;  6'd45: round_const = 32'hd6990624;
            6'd46: round_const = 32'hf40e3585;  6'd47: round_const = 32'h106aa070;
            6'd48: round_const = 32'h19a4c116;  6'd49: round_const = 32'h1e376c08;
            6'd50: round_const = 32'h2748774c;  6'd51: round_const = 32'h34b0bcb5;
            6'd52: round_const = 32'h391c0cb3;  6'd53: round_const = 32'h4ed8aa4a;
            6'd54: round_const = 32'h5b9cca4f;  6'd55: round_const = 32'h682e6ff3;
            6'd56: round_const = 32'h748f82ee;  6'd57: round_const = 32'h78a5636f;
            6'd58: round_const = 32'h84c87814;  6'd59: round_const = 32'h8cc70208;
            6'd60: round_const = 32'h90befffa;  6'd61: round_const = 32'ha4506ceb;
            6'd62: round_const = 32'hbef9a3f7;  6'd63: round_const = 32'hc67178f2;
            default: round_const = 32'h0;
        endcase
    endfunction

endpackage

// ----- design/sha_front.sv -----
// ----------------------------------------------------------------------------
// sha_front
// Collects message bytes into a 512-bit block, counts message bits and
// generates the padding bytes after a finish request.
// ----------------------------------------------------------------------------
module sha_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sha_pkg::t_in_item i_item,
    output logic           o_full,
    output logic           o_q_push,
    output sha_pkg::t_job  o_q_job,
    input  logic           i_q_full
);

    sha_pkg::t_front_state r_state, n_state;
    logic [511:0] r_buf, n_buf;
    logic [5:0]   r_fill, n_fill;
    logic [63:0]  r_bits, n_bits;
    logic [63:0]  r_len, n_len;

    logic       at_end;
    logic       take;
    logic       finish;
    logic       step;
    logic       shift;
    logic       len_slot;
    logic [7:0] len_byte;
    logic [7:0] pad_byte;
    logic [7:0] new_byte;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha_pkg::F_IDLE;
            r_fill  <= '0;
            r_bits  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
        end
    end

    // block buffer and latched length
    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        r_len <= n_len;
    end

    // byte selection and next state
    always_comb begin
        at_end   = (r_fill == sha_pkg::LAST_POS);
        o_full   = (r_state != sha_pkg::F_IDLE) || (at_end && i_q_full);
        take     = i_push && !o_full && (i_item.kind == sha_pkg::KIND_APPEND);
        finish   = i_push && !o_full && (i_item.kind == sha_pkg::KIND_FINISH);
        step     = (r_state != sha_pkg::F_IDLE) && !(at_end && i_q_full);
        shift    = take || step;
        len_byte = 8'(r_len >> {~r_fill[2:0], 3'b000});
        len_slot = (r_state == sha_pkg::F_LEN) ||
                   ((r_state == sha_pkg::F_ZERO) && (r_fill == sha_pkg::LEN_POS));
        if (r_state == sha_pkg::F_MARK) begin
            pad_byte = sha_pkg::PAD_MARK;
        end else if (len_slot) begin
            pad_byte = len_byte;
        end else begin
            pad_byte = 8'h00;
        end
        new_byte = take ? i_item.message_byte : pad_byte;

        o_q_push              = shift && at_end;
        o_q_job.data          = {r_buf[503:0], new_byte};
        o_q_job.final_block   = (r_state == sha_pkg::F_LEN);

        n_state = r_state;
        n_buf   = r_buf;
        n_fill  = r_fill;
        n_bits  = r_bits;
        n_len   = r_len;
        if (shift) begin
            n_buf  = {r_buf[503:0], new_byte};
            n_fill = r_fill + 6'd1;
        end
        if (take) begin
            n_bits = r_bits + 64'd8;
        end
        if (finish) begin
            n_len   = r_bits;
            n_bits  = '0;
            n_state = sha_pkg::F_MARK;
        end
        if (step) begin
            case (r_state)
                sha_pkg::F_MARK: n_state = sha_pkg::F_ZERO;
                sha_pkg::F_ZERO: if (r_fill == sha_pkg::LEN_POS) n_state = sha_pkg::F_LEN;
                sha_pkg::F_LEN:  if (at_end) n_state = sha_pkg::F_IDLE;
                default:         n_state = sha_pkg::F_IDLE;
            endcase
        end
    end

endmodule

// ----- design/sha_queue.sv -----
// ----------------------------------------------------------------------------
// sha_queue
// Small block queue that decouples byte collection from the round engine.
// ----------------------------------------------------------------------------
module sha_queue #(
    parameter int unsigned DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sha_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output sha_pkg::t_job o_job,
    output logic          o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sha_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_comb begin
        o_full  = (r_count == CW'(DEPTH));
        o_empty = (r_count == '0);
        o_job   = r_mem[r_rd];
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

endmodule

// ----- design/sha_back.sv -----
// ----------------------------------------------------------------------------
// sha_back
// Round engine: 64 compression rounds at one per cycle with a rolling
// 16-word message schedule, chaining update and digest word output.
// ----------------------------------------------------------------------------
module sha_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  sha_pkg::t_job  i_q_job,
    output logic           o_q_pop,
    output logic           o_empty,
    output sha_pkg::t_out_item o_result,
    input  logic           i_pop
);

    sha_pkg::t_back_state r_state, n_state;
    logic [31:0] r_h [8];
    logic [31:0] n_h [8];
    logic [31:0] r_v [8];
    logic [31:0] n_v [8];
    logic [31:0] r_w [16];
    logic [31:0] n_w [16];
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_eidx, n_eidx;
    logic        r_final, n_final;
    logic        r_ov, n_ov;
    sha_pkg::t_out_item r_out, n_out;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_next;
    logic        load_out;

    // control registers and chaining words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha_pkg::B_IDLE;
            r_round <= '0;
            r_eidx  <= '0;
            r_final <= 1'b0;
            r_ov    <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha_pkg::H_INIT[255 - 32*i -: 32];
            end
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_eidx  <= n_eidx;
            r_final <= n_final;
            r_ov    <= n_ov;
            r_h     <= n_h;
        end
    end

    // working variables, schedule window and output word
    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_w   <= n_w;
        r_out <= n_out;
    end

    // one compression round
    always_comb begin
        t1 = r_v[7] + sha_pkg::big_sigma1(r_v[4]) +
             ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) +
             sha_pkg::round_const(r_round) + r_w[0];
        t2 = sha_pkg::big_sigma0(r_v[0]) +
             ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_next = r_w[0] + sha_pkg::small_sigma0(r_w[1]) + r_w[9] +
                 sha_pkg::small_sigma1(r_w[14]);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_v     = r_v;
        n_w     = r_w;
        n_round = r_round;
        n_eidx  = r_eidx;
        n_final = r_final;
        n_ov    = r_ov;
        n_out   = r_out;
        o_q_pop = 1'b0;
        load_out = (r_state == sha_pkg::B_EMIT) && (!r_ov || i_pop);

        if (r_ov && i_pop) begin
            n_ov = 1'b0;
        end

        case (r_state)
            sha_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_final = i_q_job.final_block;
                    n_v     = r_h;
                    n_round = '0;
                    for (int i = 0; i < 16; i++) begin
                        n_w[i] = i_q_job.data[511 - 32*i -: 32];
                    end
                    n_state = sha_pkg::B_ROUND;
                end
            end
            sha_pkg::B_ROUND: begin
                n_v[0] = t1 + t2;
                n_v[1] = r_v[0];
                n_v[2] = r_v[1];
                n_v[3] = r_v[2];
                n_v[4] = r_v[3] + t1;
                n_v[5] = r_v[4];
                n_v[6] = r_v[5];
                n_v[7] = r_v[6];
                for (int i = 0; i < 15; i++) begin
                    n_w[i] = r_w[i+1];
                end
                n_w[15] = w_next;
                n_round = r_round + 6'd1;
                if (r_round == sha_pkg::LAST_ROUND) begin
                    n_state = sha_pkg::B_ADD;
                end
            end
            sha_pkg::B_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                n_eidx  = '0;
                n_state = r_final ? sha_pkg::B_EMIT : sha_pkg::B_IDLE;
            end
            sha_pkg::B_EMIT: begin
                if (load_out) begin
                    n_ov              = 1'b1;
                    n_out.digest_word = r_h[r_eidx];
                    n_out.word_index  = r_eidx;
                    n_out.last        = (r_eidx == sha_pkg::LAST_WORD);
                    n_eidx            = r_eidx + 3'd1;
                    if (r_eidx == sha_pkg::LAST_WORD) begin
                        for (int i = 0; i < 8; i++) begin
                            n_h[i] = sha_pkg::H_INIT[255 - 32*i -: 32];
                        end
                        n_state = sha_pkg::B_IDLE;
                    end
                end
            end
            default: n_state = sha_pkg::B_IDLE;
        endcase

        o_empty  = !r_ov;
        o_result = r_out;
    end

endmodule

// ----- design/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 of a byte stream: append requests feed bytes, a finish request
// pads the message and yields the eight digest words.
// ----------------------------------------------------------------------------
// An append request is taken whenever full is low; full rises on a block's
// last byte while the block queue is full. The front buffers 64 bytes per
// block and hands each block to a small queue; the round engine loads each
// block, runs 64 rounds and does the chaining add, so long messages run at
// a rate set by the round engine. A finish request holds full high while
// the padding bytes are generated, and longer while the block queue is
// full; the digest words then appear one per cycle, as long as each is
// popped, after the last block's rounds, word 0 first, with last set on
// word 7. The chaining words return to the initial values after the digest,
// so the next request starts a new message.
module sha256_stream_hasher #(
    parameter int unsigned QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  sha_pkg::t_in_item  i_item,
    output logic               full,
    output logic               empty,
    output sha_pkg::t_out_item o_result,
    input  logic               pop
);

    logic          w_q_push;
    logic          w_q_full;
    sha_pkg::t_job w_push_job;
    logic          w_q_pop;
    logic          w_q_empty;
    sha_pkg::t_job w_pop_job;

    // byte collection and padding
    sha_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .o_full   (full),
        .o_q_push (w_q_push),
        .o_q_job  (w_push_job),
        .i_q_full (w_q_full)
    );

    // block queue
    sha_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_job   (w_pop_job),
        .o_empty (w_q_empty)
    );

    // round engine and digest output
    sha_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_job   (w_pop_job),
        .o_q_pop   (w_q_pop),
        .o_empty   (empty),
        .o_result  (o_result),
        .i_pop     (pop)
    );

    // a block is never pushed into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("block pushed into full queue");

    // last flag marks exactly the final digest word
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.last == (o_result.word_index == sha_pkg::LAST_WORD)))
        else $error("last flag disagrees with word index");

    // a finish request blocks input while padding runs
    a_finish_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && (i_item.kind == sha_pkg::KIND_FINISH)) |=> full)
        else $error("input taken during padding");

endmodule
